### sv/wnm_pkg.sv
package wnm_pkg;

  // Fixed field widths of the pattern registers and ports
  localparam int unsigned PAT_SLOTS   = 11;
  localparam int unsigned FIRST_CHARS = 6;
  localparam int unsigned FIRST_W     = 48;
  localparam int unsigned REST_W      = 40;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  // Character codes used by the matcher
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] LOW7_MASK  = 8'h7F;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_FIRST  = 2'd0,
    CFG_PATTERN_REST   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } wnm_cfg_idx_t;

  // Per-cell control, set up by the top level for each position
  typedef struct packed {
    logic home;     // position zero, live after clearing
    logic in_pat;   // position lies inside the pattern
    logic is_end;   // position is the pattern end
    logic consume;  // an item carrying a byte is taken this cycle
    logic clear;    // the name ends this cycle
  } wnm_cell_ctrl_t;

  // Per-cell status returned to the top level
  typedef struct packed {
    logic acc;      // this position accepts on the current byte
    logic fin;      // this position accepts at name end
    logic live;     // stored live bit
    logic star;     // stored sticky bit
  } wnm_cell_stat_t;

  // Upper-case folding of a..z, everything else unchanged
  function automatic logic [7:0] fold_char(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      res = ch - 8'h20;
    end
    return res;
  endfunction

endpackage

### sv/wnm_cell.sv
module wnm_cell
  import wnm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  wnm_cell_ctrl_t ctrl,
  input  logic [7:0]     pchar,
  input  logic [7:0]     name_byte,
  input  logic           run_in,
  output logic           run_out,
  input  logic           adv_in,
  output logic           adv_out,
  output wnm_cell_stat_t stat
);

  logic       live_r, live_nxt;
  logic       star_r, star_nxt;
  logic [6:0] low7;
  logic       is_star;
  logic       hit;
  logic       add;
  logic       live_now;
  logic       lit_ok;
  logic       acc_run;
  logic       acc_main;
  logic       chk_live;

  assign low7    = name_byte[6:0] & LOW7_MASK[6:0];
  assign is_star = ctrl.in_pat && (pchar == CHAR_STAR);

  // A star run carries on to the right while it is reached or entered here.
  assign run_out = is_star && (live_r || star_r || run_in);

  // The first non-star position after a live run becomes live and sticky,
  // unless it is a space, in which case the name is accepted.
  assign hit     = run_in && ctrl.in_pat && !is_star;
  assign add     = hit && (pchar != CHAR_SPACE);
  assign acc_run = (hit && (pchar == CHAR_SPACE)) || (run_in && ctrl.is_end);

  assign live_now = ((live_r || star_r) && (ctrl.in_pat || ctrl.is_end)) || add;

  // Literal comparison is case-insensitive on the low seven bits.
  assign lit_ok = (fold_char({1'b0, low7}) == fold_char(pchar));

  assign adv_out = live_now && ctrl.in_pat && !is_star &&
                   ((pchar == CHAR_QMARK) || (lit_ok && ({1'b0, low7} != CHAR_SPACE)));

  assign acc_main = live_now &&
                    ((ctrl.is_end && (name_byte == CHAR_SPACE)) ||
                     (ctrl.in_pat && !is_star && (pchar != CHAR_QMARK) && lit_ok &&
                      ({1'b0, low7} == CHAR_SPACE)));

  // Name-end check looks at the live bit as it stands after this item.
  assign chk_live = ctrl.consume ? adv_in : live_r;

  assign stat.acc  = acc_run || acc_main;
  assign stat.fin  = chk_live &&
                     (ctrl.is_end ||
                      (ctrl.in_pat && ((pchar == CHAR_SPACE) || (pchar == CHAR_STAR))));
  assign stat.live = live_r;
  assign stat.star = star_r;

  // Next state of the position
  always_comb begin
    live_nxt = live_r;
    star_nxt = star_r;
    if (ctrl.clear) begin
      live_nxt = ctrl.home;
      star_nxt = 1'b0;
    end else if (ctrl.consume) begin
      live_nxt = adv_in;
      star_nxt = star_r || add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= ctrl.home;
      star_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
      star_r <= star_nxt;
    end
  end

endmodule

### sv/wildcard_name_matcher_top.sv
// Wildcard name matcher. A file name streams in one byte per item and is
// matched against a pattern of up to MAX_PATTERN characters held in three
// configuration registers; '?' matches any byte, '*' any run, and letters
// compare without regard to case. The block takes one item every cycle
// while in_stall is low, with no gaps between names. The match state
// sits in a row of MAX_PATTERN + 1 position cells that all update in the
// same cycle; a star run ripples through the row within that cycle. The
// single match bit of a name appears on the output register in the cycle
// after its final item is accepted, and the cells are cleared at that
// same edge, so the next name may follow at once. The name channel is
// stalled only while a finished result waits in the output register with
// out_stall high. An item with no_byte set and name_end clear is ignored.
module wildcard_name_matcher_top
  import wnm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIRST_W-1:0]   cfg_data,
  // Name byte channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_name_byte,
  input  logic                 in_name_end,
  input  logic                 in_no_byte,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_matched
);

  localparam int unsigned LAST = MAX_PATTERN;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [FIRST_W-1:0] pattern_first_r;
  logic [REST_W-1:0]  pattern_rest_r;
  logic [LEN_W-1:0]   pattern_length_r;
  logic [LEN_W-1:0]   len;
  logic [7:0]         chars [0:PAT_SLOTS];

  logic               accepted_r, accepted_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_matched_r, out_matched_nxt;

  logic               accept_in;
  logic               consume;
  logic               done;
  logic               acc_any;
  logic               fin_any;

  wnm_cell_ctrl_t     ctrl [0:LAST];
  wnm_cell_stat_t     stat [0:LAST];
  logic [LAST+1:0]    run_c;
  logic [LAST+1:0]    adv_c;
  logic [LAST:0]      acc_v;
  logic [LAST:0]      fin_v;
  logic [LAST:0]      live_v;
  logic [LAST:0]      star_v;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_first_r  <= '0;
      pattern_rest_r   <= '0;
      pattern_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_FIRST:  pattern_first_r  <= cfg_data;
        CFG_PATTERN_REST:   pattern_rest_r   <= cfg_data[REST_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, limited to MAX_PATTERN
  assign len = (pattern_length_r > MAX_LEN) ? MAX_LEN : pattern_length_r;

  // Pattern characters unpacked from the two registers; the slot past the
  // last character slot holds zero and feeds the last cell.
  for (genvar k = 0; k < PAT_SLOTS; k++) begin : g_chars
    if (k < FIRST_CHARS) begin : g_first
      assign chars[k] = pattern_first_r[8*k +: 8];
    end else begin : g_rest
      assign chars[k] = pattern_rest_r[8*(k-FIRST_CHARS) +: 8];
    end
  end
  assign chars[PAT_SLOTS] = 8'h00;

  // Handshake of the name channel
  assign in_stall  = out_valid_r && out_stall;
  assign accept_in = in_valid && !in_stall;
  assign consume   = accept_in && !in_no_byte;
  assign done      = accept_in && in_name_end;

  // Row of position cells
  assign run_c[0] = 1'b0;
  assign adv_c[0] = 1'b0;

  for (genvar p = 0; p <= LAST; p++) begin : g_cell
    assign ctrl[p].home    = (p == 0);
    assign ctrl[p].in_pat  = (LEN_W'(p) < len);
    assign ctrl[p].is_end  = (LEN_W'(p) == len);
    assign ctrl[p].consume = consume;
    assign ctrl[p].clear   = done;

    wnm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[p]),
      .pchar     (chars[p]),
      .name_byte (in_name_byte),
      .run_in    (run_c[p]),
      .run_out   (run_c[p+1]),
      .adv_in    (adv_c[p]),
      .adv_out   (adv_c[p+1]),
      .stat      (stat[p])
    );

    assign acc_v[p]  = stat[p].acc;
    assign fin_v[p]  = stat[p].fin;
    assign live_v[p] = stat[p].live;
    assign star_v[p] = stat[p].star;
  end

  assign acc_any = |acc_v;
  assign fin_any = |fin_v;

  // Sticky accept flag and result register
  always_comb begin
    accepted_nxt    = accepted_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (consume) begin
      accepted_nxt = accepted_r || acc_any;
    end
    if (done) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = accepted_nxt || fin_any;
      accepted_nxt    = 1'b0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      accepted_r  <= accepted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // The final item of a name always leaves a result behind.
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r)
    else $error("name end did not load a result");

  // The name channel is held back only by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled without a pending result");

  // After a name ends the cells and the accept flag are back at rest.
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (live_v == {{LAST{1'b0}}, 1'b1}) && (star_v == '0) && !accepted_r)
    else $error("match state not cleared after name end");

  // An empty item inside a name leaves the match state alone.
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_in && in_no_byte && !in_name_end) |=>
      $stable(live_v) && $stable(star_v) && $stable(accepted_r))
    else $error("empty item changed the match state");

  // Nothing ripples out past the last position of the row.
  a_chain_end: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> !run_c[LAST+1] && !adv_c[LAST+1])
    else $error("activity past the last position");

endmodule
